// ----- src/uvs_pkg.sv -----
package uvs_pkg;

  // Stack depth and derived widths
  localparam int unsigned DEPTH = 8;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = $clog2(DEPTH);
  localparam int unsigned IDX_W = 3;
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned DATA_W = 32;

  // Result position when there is none
  localparam logic [3:0] POS_NONE = 4'hF;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_READ   = 2'd3
  } uvs_kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_RANGE    = 3'd5
  } uvs_status_e;

  // Per-cell update controls
  typedef struct packed {
    logic load;   // take the insert value
    logic shift;  // take the upper neighbor's value
  } uvs_cell_ctl_t;

endpackage

// ----- src/uvs_cell.sv -----
module uvs_cell
  import uvs_pkg::*;
(
  input  logic                      clk_i,
  input  uvs_cell_ctl_t             ctl_i,
  input  logic signed [DATA_W-1:0]  wr_data_i,
  input  logic signed [DATA_W-1:0]  upper_i,
  input  logic signed [DATA_W-1:0]  cmp_i,
  input  logic                      occ_i,
  output logic signed [DATA_W-1:0]  entry_o,
  output logic                      match_o
);

  logic signed [DATA_W-1:0] entry_q, entry_d;

  // Load on insert, shift down on remove, otherwise hold
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.load) begin
      entry_d = wr_data_i;
    end else if (ctl_i.shift) begin
      entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Compare against the search value when occupied
  assign match_o = occ_i && (entry_q == cmp_i);
  assign entry_o = entry_q;

endmodule

// ----- src/unique_value_stack_with_delete.sv -----
// Bounded stack of signed 32-bit values that never holds a value twice.
//
// Input channel (in_valid_i / in_ready_o): one operation per transaction,
// kind_i selects insert, remove by value, find, or read at index_i.
// Output channel (out_valid_o / out_ready_i): exactly one result per
// operation, carrying status_o, position_o, read_value_o and count_o.
//
// The result is registered at the edge that accepts the operation. The block
// takes one operation per cycle unless the receiver stalls; the row of entry
// cells allows this, as they all compare in parallel and shift down in one step.
//
// When the receiver stalls, the pending result holds in the output register
// and in_ready_o drops until it is taken; in_ready_o is high whenever the
// output register is empty or being emptied in the same cycle.
//
// Reset empties the stack (count zero) and clears the output valid; no
// clearing pass is needed, so operations are taken right after reset.
module unique_value_stack_with_delete
  import uvs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               kind_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [IDX_W-1:0]         index_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output logic signed [3:0]        position_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [3:0]               count_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  uvs_status_e      status_q, status_d;
  logic [3:0]       position_q, position_d;
  logic signed [DATA_W-1:0] read_value_q, read_value_d;

  uvs_cell_ctl_t            ctl   [DEPTH];
  logic signed [DATA_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]         match;
  logic [DEPTH-1:0]         occ;

  logic             accept;
  logic             full;
  logic             empty;
  logic             hit;
  logic [POS_W-1:0] hit_pos;
  logic             do_insert;
  logic             do_remove;
  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic signed [DATA_W-1:0] sel_value;
  uvs_kind_e        kind;

  assign kind      = uvs_kind_e'(kind_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign idx_ext   = CMP_W'(index_i);
  assign cnt_ext   = CMP_W'(count_q);

  assign do_insert = accept && (kind == KIND_INSERT) && !full && !hit;
  assign do_remove = accept && (kind == KIND_REMOVE) && hit;

  // Row of entry cells
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    assign occ[j] = (CNT_W'(j) < count_q);

    always_comb begin
      ctl[j].load  = do_insert && (count_q == CNT_W'(j));
      ctl[j].shift = do_remove && (POS_W'(j) >= hit_pos) && (CNT_W'(j + 1) < count_q);
    end

    if (j == DEPTH - 1) begin : g_top
      uvs_cell u_cell (
        .clk_i     (clk_i),
        .ctl_i     (ctl[j]),
        .wr_data_i (value_i),
        .upper_i   (entry[j]),
        .cmp_i     (value_i),
        .occ_i     (occ[j]),
        .entry_o   (entry[j]),
        .match_o   (match[j])
      );
    end else begin : g_mid
      uvs_cell u_cell (
        .clk_i     (clk_i),
        .ctl_i     (ctl[j]),
        .wr_data_i (value_i),
        .upper_i   (entry[j+1]),
        .cmp_i     (value_i),
        .occ_i     (occ[j]),
        .entry_o   (entry[j]),
        .match_o   (match[j])
      );
    end
  end

  // Encode the matching cell (values are unique, at most one hit)
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int unsigned j = 0; j < DEPTH; j++) begin
      if (match[j]) begin
        hit     = 1'b1;
        hit_pos = POS_W'(j);
      end
    end
  end

  // Select the entry at the read index
  always_comb begin
    sel_value = '0;
    for (int unsigned j = 0; j < DEPTH; j++) begin
      if (CMP_W'(j) == idx_ext) begin
        sel_value = entry[j];
      end
    end
  end

  // Form the result and the next count
  always_comb begin
    status_d     = ST_OK;
    position_d   = POS_NONE;
    read_value_d = '0;
    count_d      = count_q;
    case (kind)
      KIND_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (hit) begin
          status_d   = ST_DUP;
          position_d = 4'(hit_pos);
        end else begin
          position_d = 4'(count_q);
          count_d    = count_q + CNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!hit) begin
          status_d = ST_NOTFOUND;
        end else begin
          position_d = 4'(hit_pos);
          count_d    = count_q - CNT_W'(1);
        end
      end
      KIND_FIND: begin
        if (hit) begin
          position_d = 4'(hit_pos);
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      KIND_READ: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (idx_ext >= cnt_ext) begin
          status_d = ST_RANGE;
        end else begin
          read_value_d = sel_value;
          position_d   = 4'(index_i);
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Output valid: set on a new transaction, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Hold the result payload until the next transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= status_d;
      position_q   <= position_d;
      read_value_q <= read_value_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign position_o   = position_q;
  assign read_value_o = read_value_q;
  assign count_o      = 4'(count_q);

endmodule

// ----- src/uvs_checker.sv -----
module uvs_checker
  import uvs_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [2:0]               status_o,
  input logic signed [3:0]        position_o,
  input logic signed [DATA_W-1:0] read_value_o,
  input logic [3:0]               count_o
);

  // A stalled result stays pending
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Failed operations other than a duplicate insert carry no position
  a_fail_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_EMPTY ||
                    status_o == ST_NOTFOUND || status_o == ST_RANGE)
    |-> position_o == POS_NONE)
    else $error("failed operation reports a position");

  // Only a successful read returns data
  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_value_o != '0) |-> status_o == ST_OK)
    else $error("data returned with an error status");

  // Empty status means nothing is held
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> count_o == 4'd0)
    else $error("empty status with entries held");

  // Full status means the stack is at depth
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == 4'(DEPTH))
    else $error("full status below depth");

endmodule

bind unique_value_stack_with_delete uvs_checker u_uvs_checker (.*);
